@@ hw/rtl/bfsam_pkg.sv @@
// Package for the breadth-first search block: sizes, action and state codes,
// and the result type of the find-first-set unit.
// No dependencies.
`default_nettype none

package bfsam_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned VERT_W       = 6;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned ROW_W        = 64;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = CNT_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ACT_ADD_EDGE = 2'd0,
    ACT_SEARCH   = 2'd1,
    ACT_CLEAR    = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RD_A,
    ST_EDGE_WR_A,
    ST_EDGE_RD_B,
    ST_EDGE_WR_B,
    ST_DEQUEUE,
    ST_FETCH,
    ST_LOAD,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic              found;
    logic [VERT_W-1:0] index;
    logic [ROW_W-1:0]  onehot;
    logic [ROW_W-1:0]  rest;
  } ffs_t;

endpackage

`default_nettype wire

@@ hw/rtl/bfsam_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; used for the adjacency rows and the vertex queue.
`default_nettype none

module bfsam_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bfsam_ffs.sv @@
// Find-first-set unit: picks the lowest set bit of a candidate row.
// Depends on bfsam_pkg.
`default_nettype none

module bfsam_ffs (
  input  wire logic [bfsam_pkg::ROW_W-1:0] cand_i,
  output bfsam_pkg::ffs_t                  res_o
);

  logic [bfsam_pkg::ROW_W-1:0]  low;
  logic [bfsam_pkg::VERT_W-1:0] index;

  assign low = cand_i & (~cand_i + bfsam_pkg::ROW_W'(1));

  always_comb begin
    index = '0;
    for (int i = 0; i < bfsam_pkg::ROW_W; i++) begin
      if (low[i]) begin
        index = index | bfsam_pkg::VERT_W'(i);
      end
    end
  end

  assign res_o.found  = |cand_i;
  assign res_o.index  = index;
  assign res_o.onehot = low;
  assign res_o.rest   = cand_i & ~low;

endmodule

`default_nettype wire

@@ hw/rtl/bfs_adjacency_matrix.sv @@
// Top level of the breadth-first search block: sequencer, visited mask and
// configuration port. Depends on bfsam_pkg, bfsam_ram and bfsam_ffs.
//
// Usage. A command word is taken when start is high and busy is low.
// action 0 adds an undirected edge between vertex_a_i and vertex_b_i,
// action 2 clears the graph, action 1 searches from start_vertex_i.
// An edge with an endpoint at or beyond the vertex count is ignored, as is
// a search from such a start vertex, which gives no results.
// Add edge keeps busy high until ST_EDGE_WR_B is done; clear graph and
// ignored words leave the block idle, so the next word may follow in the next cycle.
// A search emits one result word per dequeued vertex in breadth-first order,
// with last_o set on the final one. For each vertex the states ST_DEQUEUE,
// ST_FETCH and ST_LOAD fetch its queue entry and matrix row; ST_SCAN then
// enqueues each new neighbour in turn through the find-first-set unit and
// emits the result word. Each result word is on the result ports for one
// cycle, marked by result_valid_o; the receiver cannot stall it. The user
// must see that vertex_count is written over the APB-style port at byte
// address 0 only while the block is idle; the block does not enforce it.
// Reset clears the graph through per-row valid bits at once, so no clearing
// pass is needed, and sets the vertex count to 64.
`default_nettype none

module bfs_adjacency_matrix (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     action_i,
  input  wire logic [bfsam_pkg::VERT_W-1:0]   vertex_a_i,
  input  wire logic [bfsam_pkg::VERT_W-1:0]   vertex_b_i,
  input  wire logic [bfsam_pkg::VERT_W-1:0]   start_vertex_i,
  output logic                                result_valid_o,
  output logic      [bfsam_pkg::VERT_W-1:0]   visited_vertex_o,
  output logic                                last_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bfsam_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bfsam_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bfsam_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);

  localparam int unsigned VW = bfsam_pkg::VERT_W;
  localparam int unsigned CW = bfsam_pkg::CNT_W;
  localparam int unsigned RW = bfsam_pkg::ROW_W;

  bfsam_pkg::state_e state_q, state_d;

  logic [CW-1:0] vcount_q;
  logic [CW-1:0] n_eff;
  logic [RW-1:0] nmask;

  logic [RW-1:0] row_valid_q, row_valid_d;
  logic          rvld_q, rvld_d;
  logic [RW-1:0] visited_q, visited_d;
  logic [RW-1:0] cand_q, cand_d;
  logic [CW-1:0] head_q, head_d;
  logic [CW-1:0] tail_q, tail_d;
  logic [VW-1:0] va_q, va_d;
  logic [VW-1:0] vb_q, vb_d;
  logic [VW-1:0] cur_q, cur_d;

  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_vertex_q, out_vertex_d;
  logic          out_last_q, out_last_d;

  logic          row_we, row_re;
  logic [VW-1:0] row_waddr, row_raddr;
  logic [RW-1:0] row_wdata, row_rdata;

  logic          q_we, q_re;
  logic [VW-1:0] q_waddr, q_raddr;
  logic [VW-1:0] q_wdata, q_rdata;

  bfsam_pkg::ffs_t ffs_res;

  logic accept;
  logic cfg_write;

  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  assign n_eff = (vcount_q > CW'(bfsam_pkg::MAX_VERTICES)) ?
                 CW'(bfsam_pkg::MAX_VERTICES) : vcount_q;

  always_comb begin
    for (int i = 0; i < RW; i++) begin
      nmask[i] = (CW'(i) < n_eff);
    end
  end

  bfsam_ram #(
    .WIDTH (RW),
    .DEPTH (bfsam_pkg::MAX_VERTICES)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  bfsam_ram #(
    .WIDTH (VW),
    .DEPTH (bfsam_pkg::MAX_VERTICES)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  bfsam_ffs u_ffs (
    .cand_i (cand_q),
    .res_o  (ffs_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfsam_pkg::ST_IDLE;
      vcount_q    <= bfsam_pkg::VERTEX_COUNT_RESET;
      row_valid_q <= '0;
      visited_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      visited_q   <= visited_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
      if (cfg_write && (paddr[2] == bfsam_pkg::REG_VERTEX_COUNT)) begin
        vcount_q <= pwdata[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rvld_q       <= rvld_d;
    cand_q       <= cand_d;
    va_q         <= va_d;
    vb_q         <= vb_d;
    cur_q        <= cur_d;
    out_vertex_q <= out_vertex_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    row_valid_d  = row_valid_q;
    rvld_d       = rvld_q;
    visited_d    = visited_q;
    cand_d       = cand_q;
    head_d       = head_q;
    tail_d       = tail_q;
    va_d         = va_q;
    vb_d         = vb_q;
    cur_d        = cur_q;
    out_valid_d  = 1'b0;
    out_vertex_d = out_vertex_q;
    out_last_d   = out_last_q;
    row_we       = 1'b0;
    row_re       = 1'b0;
    row_waddr    = va_q;
    row_raddr    = va_q;
    row_wdata    = '0;
    q_we         = 1'b0;
    q_re         = 1'b0;
    q_waddr      = tail_q[VW-1:0];
    q_raddr      = head_q[VW-1:0];
    q_wdata      = ffs_res.index;

    unique case (state_q)
      bfsam_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (action_i)
            bfsam_pkg::ACT_ADD_EDGE: begin
              va_d = vertex_a_i;
              vb_d = vertex_b_i;
              if ((CW'(vertex_a_i) < n_eff) && (CW'(vertex_b_i) < n_eff)) begin
                state_d = bfsam_pkg::ST_EDGE_RD_A;
              end
            end
            bfsam_pkg::ACT_SEARCH: begin
              if (CW'(start_vertex_i) < n_eff) begin
                visited_d = RW'(1) << start_vertex_i;
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = start_vertex_i;
                head_d    = '0;
                tail_d    = CW'(1);
                state_d   = bfsam_pkg::ST_DEQUEUE;
              end
            end
            bfsam_pkg::ACT_CLEAR: begin
              row_valid_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      bfsam_pkg::ST_EDGE_RD_A: begin
        row_re    = 1'b1;
        row_raddr = va_q;
        rvld_d    = row_valid_q[va_q];
        state_d   = bfsam_pkg::ST_EDGE_WR_A;
      end
      bfsam_pkg::ST_EDGE_WR_A: begin
        row_we             = 1'b1;
        row_waddr          = va_q;
        row_wdata          = (rvld_q ? row_rdata : '0) | (RW'(1) << vb_q);
        row_valid_d[va_q]  = 1'b1;
        state_d            = bfsam_pkg::ST_EDGE_RD_B;
      end
      bfsam_pkg::ST_EDGE_RD_B: begin
        row_re    = 1'b1;
        row_raddr = vb_q;
        rvld_d    = row_valid_q[vb_q];
        state_d   = bfsam_pkg::ST_EDGE_WR_B;
      end
      bfsam_pkg::ST_EDGE_WR_B: begin
        row_we             = 1'b1;
        row_waddr          = vb_q;
        row_wdata          = (rvld_q ? row_rdata : '0) | (RW'(1) << va_q);
        row_valid_d[vb_q]  = 1'b1;
        state_d            = bfsam_pkg::ST_IDLE;
      end
      bfsam_pkg::ST_DEQUEUE: begin
        q_re    = 1'b1;
        q_raddr = head_q[VW-1:0];
        head_d  = head_q + CW'(1);
        state_d = bfsam_pkg::ST_FETCH;
      end
      bfsam_pkg::ST_FETCH: begin
        cur_d     = q_rdata;
        row_re    = 1'b1;
        row_raddr = q_rdata;
        rvld_d    = row_valid_q[q_rdata];
        state_d   = bfsam_pkg::ST_LOAD;
      end
      bfsam_pkg::ST_LOAD: begin
        cand_d  = (rvld_q ? row_rdata : '0) & ~visited_q & nmask;
        state_d = bfsam_pkg::ST_SCAN;
      end
      bfsam_pkg::ST_SCAN: begin
        if (ffs_res.found) begin
          if (!tail_q[CW-1]) begin
            q_we      = 1'b1;
            q_waddr   = tail_q[VW-1:0];
            q_wdata   = ffs_res.index;
            tail_d    = tail_q + CW'(1);
            visited_d = visited_q | ffs_res.onehot;
            cand_d    = ffs_res.rest;
          end else begin
            cand_d = '0;
          end
        end else begin
          out_valid_d  = 1'b1;
          out_vertex_d = cur_q;
          out_last_d   = (head_q == tail_q);
          if ((head_q == tail_q) || head_q[CW-1]) begin
            state_d = bfsam_pkg::ST_IDLE;
          end else begin
            state_d = bfsam_pkg::ST_DEQUEUE;
          end
        end
      end
      default: begin
        state_d = bfsam_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_q != bfsam_pkg::ST_IDLE);
  assign result_valid_o   = out_valid_q;
  assign visited_vertex_o = out_vertex_q;
  assign last_o           = out_last_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bfsam_pkg::REG_VERTEX_COUNT) ?
                  bfsam_pkg::PDATA_W'(vcount_q) : '0;

endmodule

`default_nettype wire
